[hw/rtl/pdc_pkg.sv]
// pdc_pkg: item types and fixed constants for the point distance colour map.
// No dependencies; imported by point_distance_colormap_unit and pdc_checker.
`timescale 1ns / 1ps

package pdc_pkg;

    typedef struct packed {
        logic               kind;
        logic               start_req;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic signed [15:0] z_coord;
    } point_item_t;

    typedef struct packed {
        logic signed [15:0] x_out;
        logic signed [15:0] y_out;
        logic signed [15:0] z_out;
        logic        [7:0]  red;
        logic        [7:0]  green;
        logic        [7:0]  blue;
        logic        [15:0] distance;
    } result_item_t;

    localparam logic       KIND_MEASURE = 1'b0;
    localparam logic       KIND_COLOUR  = 1'b1;

    localparam int         QUOT_BITS    = 8;
    localparam logic [7:0] COLOUR_MAX   = 8'd255;
    localparam logic [7:0] COLOUR_ZERO  = 8'd0;

endpackage

[hw/rtl/pdc_isqrt.sv]
// pdc_isqrt: digit-serial integer square root, two radicand bits per cycle.
// Depends on nothing; instantiated by point_distance_colormap_unit.
`timescale 1ns / 1ps

module pdc_isqrt #(
    parameter int RAD_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [RAD_BITS-1:0]   radicand,
    output logic                  done,
    output logic [RAD_BITS/2-1:0] root
);

    localparam int RB   = RAD_BITS / 2;
    localparam int RW   = RB + 2;
    localparam int CNTW = (RB > 1) ? $clog2(RB) : 1;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [RAD_BITS-1:0] rad_reg, rad_next;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [RB-1:0]       root_reg, root_next;

    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       trial;
    logic                fits;

    assign rem_sh = {rem_reg[RB-1:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_next  = fits ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[RB-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(RB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hw/rtl/point_distance_colormap_unit.sv]
// point_distance_colormap_unit: distance colour map of a twice-streamed point cloud.
// Depends on pdc_pkg and pdc_isqrt. CW = min(COORD_BITS,16).
// Measure item: CW squaring steps, CW root steps, then store of the maximum; busy until back in idle.
// Colour item: squaring, root, a QUOT_BITS-bit divide and the output load; a zero or exceeded
// maximum skips the divide. The next item is taken once the result is loaded, later if it stalls.
// Reset: asynchronous, clears control and the kept maximum to zero; one item at a time.
`timescale 1ns / 1ps

module point_distance_colormap_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_stall,
    input  pdc_pkg::point_item_t point_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output pdc_pkg::result_item_t result_data
);

    import pdc_pkg::*;

    localparam int CW   = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SW   = 2 * CW;
    localparam int NW   = CW + QUOT_BITS;
    localparam int CNTW = $clog2(CW);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_ROOT   = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]  max_reg, max_next;
    logic           res_valid_reg, res_valid_next;

    point_item_t    item_reg, item_next;
    result_item_t   res_reg, res_next;
    logic [CW-1:0]  mx_reg, mx_next, my_reg, my_next, mz_reg, mz_next;
    logic [SW-1:0]  sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic [SW-1:0]  acc_reg, acc_next;
    logic [CW-1:0]  dist_reg, dist_next;
    logic [NW-1:0]  num_reg, num_next, dv_reg, dv_next;
    logic [QUOT_BITS-1:0] q_reg, q_next;

    logic [CW-1:0]  raw_x, raw_y, raw_z, mag_x, mag_y, mag_z;
    logic [SW-1:0]  acc_sum;
    logic           root_start, root_done;
    logic [CW-1:0]  root_val;
    logic           div_ge;
    logic [7:0]     blue_val;

    assign raw_x = point_data.x_coord[CW-1:0];
    assign raw_y = point_data.y_coord[CW-1:0];
    assign raw_z = point_data.z_coord[CW-1:0];
    assign mag_x = raw_x[CW-1] ? (~raw_x + 1'b1) : raw_x;
    assign mag_y = raw_y[CW-1] ? (~raw_y + 1'b1) : raw_y;
    assign mag_z = raw_z[CW-1] ? (~raw_z + 1'b1) : raw_z;

    assign acc_sum = acc_reg + (mx_reg[0] ? sx_reg : '0) + (my_reg[0] ? sy_reg : '0)
                   + (mz_reg[0] ? sz_reg : '0);

    assign div_ge   = (num_reg >= dv_reg);
    // remainder zero: blue is the complement of red, else one less
    assign blue_val = (num_reg == '0) ? (COLOUR_MAX - q_reg) : (COLOUR_MAX - 8'd1 - q_reg);

    pdc_isqrt #(
        .RAD_BITS (SW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_sum),
        .done     (root_done),
        .root     (root_val)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        max_next       = max_reg;
        res_valid_next = res_valid_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mz_next        = mz_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sz_next        = sz_reg;
        acc_next       = acc_reg;
        dist_next      = dist_reg;
        num_next       = num_reg;
        dv_next        = dv_reg;
        q_next         = q_reg;
        root_start     = 1'b0;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (point_valid)
                begin
                    item_next  = point_data;
                    mx_next    = mag_x;
                    my_next    = mag_y;
                    mz_next    = mag_z;
                    sx_next    = SW'(mag_x);
                    sy_next    = SW'(mag_y);
                    sz_next    = SW'(mag_z);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                acc_next = acc_sum;
                mx_next  = mx_reg >> 1;
                my_next  = my_reg >> 1;
                mz_next  = mz_reg >> 1;
                sx_next  = sx_reg << 1;
                sy_next  = sy_reg << 1;
                sz_next  = sz_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(CW - 1))
                begin
                    root_start = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    dist_next = root_val;
                    if (item_reg.kind == KIND_MEASURE)
                    begin
                        if (item_reg.start_req || (root_val > max_reg))
                        begin
                            max_next = root_val;
                        end
                        state_next = ST_IDLE;
                    end
                    else if (max_reg == '0)
                    begin
                        q_next     = COLOUR_ZERO;
                        num_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else if (root_val > max_reg)
                    begin
                        q_next     = COLOUR_MAX;
                        num_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        // 255*d, then divisor aligned to the top quotient bit
                        num_next   = NW'({root_val, 8'h00}) - NW'(root_val);
                        dv_next    = {1'b0, max_reg, 7'b0000000};
                        q_next     = '0;
                        cnt_next   = '0;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                num_next = div_ge ? (num_reg - dv_reg) : num_reg;
                q_next   = {q_reg[QUOT_BITS-2:0], div_ge};
                dv_next  = dv_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QUOT_BITS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next.x_out    = item_reg.x_coord;
                    res_next.y_out    = item_reg.y_coord;
                    res_next.z_out    = item_reg.z_coord;
                    res_next.red      = q_reg;
                    res_next.green    = COLOUR_ZERO;
                    res_next.blue     = blue_val;
                    res_next.distance = 16'(dist_reg);
                    res_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            max_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            max_reg       <= max_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mz_reg   <= mz_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sz_reg   <= sz_next;
        acc_reg  <= acc_next;
        dist_reg <= dist_next;
        num_reg  <= num_next;
        dv_reg   <= dv_next;
        q_reg    <= q_next;
    end

    assign point_stall  = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

endmodule

[hw/rtl/pdc_checker.sv]
// pdc_checker: port-level assertions for point_distance_colormap_unit.
// Depends on pdc_pkg; bound to the top level below.
`timescale 1ns / 1ps

module pdc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  point_valid,
    input logic                  point_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input pdc_pkg::result_item_t result_data
);

    import pdc_pkg::*;

    logic [8:0] colour_sum;

    assign colour_sum = {1'b0, result_data.red} + {1'b0, result_data.blue};

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result item changed or dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> point_stall)
        else $error("item accepted without going busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(point_stall))
        else $error("result item appeared with no item in work");

    a_colour_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.green == COLOUR_ZERO
                         && (colour_sum == 9'd255 || colour_sum == 9'd254))
        else $error("red and blue do not complement");

endmodule

bind point_distance_colormap_unit pdc_checker u_pdc_checker (.*);
